FILE: hdl/sle_pkg.sv
package sle_pkg;

  // Operation codes carried in the kind field.
  typedef enum logic [2:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_BACK   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_FIND       = 3'd4
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_MISS  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic write_back;
  } cell_cmd_t;

endpackage

FILE: hdl/sle_in_if.sv
interface sle_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

FILE: hdl/sle_out_if.sv
interface sle_out_if #(
  parameter int DEPTH = 16
);
  localparam int PosW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [PosW-1:0] position;
  logic [CntW-1:0] count;

  modport source (output valid, output status, output position, output count, input ready);
  modport sink   (input valid, input status, input position, input count, output ready);
endinterface

FILE: hdl/sle_cell.sv
module sle_cell #(
  parameter int WORD_BITS = 32,
  parameter int POS_W     = 4,
  parameter int CNT_W     = 5,
  parameter int INDEX     = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sle_pkg::cell_cmd_t    cmd_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [WORD_BITS-1:0]  ins_word_i,
  input  logic [WORD_BITS-1:0]  lower_word_i,
  input  logic [WORD_BITS-1:0]  upper_word_i,
  output logic [WORD_BITS-1:0]  entry_o,
  input  logic                  probe_vld_i,
  input  logic [WORD_BITS-1:0]  probe_word_i,
  input  logic [CNT_W-1:0]      probe_left_i,
  input  logic                  probe_found_i,
  input  logic [POS_W-1:0]      probe_pos_i,
  output logic                  probe_vld_o,
  output logic [WORD_BITS-1:0]  probe_word_o,
  output logic [CNT_W-1:0]      probe_left_o,
  output logic                  probe_found_o,
  output logic [POS_W-1:0]      probe_pos_o
);
  import sle_pkg::*;

  logic [WORD_BITS-1:0] entry_q, entry_d;
  logic                 probe_vld_q;
  logic [WORD_BITS-1:0] probe_word_q;
  logic [CNT_W-1:0]     probe_left_q, probe_left_d;
  logic                 probe_found_q, probe_found_d;
  logic [POS_W-1:0]     probe_pos_q, probe_pos_d;
  logic                 live;
  logic                 hit;

  // Entry update: shift with the neighbors or take an append at this slot.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.shift_up) begin
      entry_d = lower_word_i;
    end else if (cmd_i.shift_down) begin
      entry_d = upper_word_i;
    end else if (cmd_i.write_back && (count_i == CNT_W'(INDEX))) begin
      entry_d = ins_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

  // The search probe compares only while it still covers occupied slots.
  assign live = (probe_left_i != '0);
  assign hit  = probe_vld_i && !probe_found_i && live && (entry_q == probe_word_i);

  always_comb begin
    probe_left_d  = live ? (probe_left_i - CNT_W'(1)) : probe_left_i;
    probe_found_d = probe_found_i || hit;
    probe_pos_d   = hit ? POS_W'(INDEX) : probe_pos_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_vld_q <= 1'b0;
    end else begin
      probe_vld_q <= probe_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_word_q  <= probe_word_i;
    probe_left_q  <= probe_left_d;
    probe_found_q <= probe_found_d;
    probe_pos_q   <= probe_pos_d;
  end

  assign probe_vld_o   = probe_vld_q;
  assign probe_word_o  = probe_word_q;
  assign probe_left_o  = probe_left_q;
  assign probe_found_o = probe_found_q;
  assign probe_pos_o   = probe_pos_q;

endmodule

FILE: hdl/sequential_list_engine_core.sv
// Ordered list of up to DEPTH signed words with push and pop at both ends
// and a search for the first entry equal to a given value.
// Input channel (in_i): kind and value; one transaction per operation.
// Output channel (out_o): status, position and count after the operation,
// exactly one result transaction per accepted input transaction.
// For push, pop and unused kind codes the result appears
// in the output register on the cycle after acceptance, and the next input
// can be taken in that same cycle if the output is drained.
// A find sends a probe down the chain of cells, one cell per cycle; its
// result is loaded into the output register after the probe leaves the last
// cell, and no new input is taken until then. The chain length sets the wait.
// All cells shift their words to a neighbor together, so pushes and pops
// at the front take no longer than those at the back.
// Reset clears the count and the controller; list words are not cleared.
// While the receiver stalls the result stays in the output register and
// no new input is accepted.
module sequential_list_engine_core #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sle_in_if.sink     in_i,
  sle_out_if.source  out_o
);
  import sle_pkg::*;

  localparam int PosW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 out_vld_q;
  status_e              out_status_q, out_status_d;
  logic [PosW-1:0]      out_pos_q, out_pos_d;
  logic [CntW-1:0]      out_count_q, out_count_d;
  logic                 out_load;
  logic                 out_free;
  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  cell_cmd_t            cmd;
  logic                 probe_start;
  logic [WORD_BITS-1:0] ins_word;
  kind_e                kind;

  logic [WORD_BITS-1:0] entry_w     [DEPTH];
  logic                 probe_vld   [DEPTH+1];
  logic [WORD_BITS-1:0] probe_word  [DEPTH+1];
  logic [CntW-1:0]      probe_left  [DEPTH+1];
  logic                 probe_found [DEPTH+1];
  logic [PosW-1:0]      probe_pos   [DEPTH+1];

  // Bring the 32-bit input word to the stored width.
  if (WORD_BITS <= 32) begin : g_narrow
    assign ins_word = in_i.value[WORD_BITS-1:0];
  end else begin : g_wide
    assign ins_word = {{(WORD_BITS - 32){in_i.value[31]}}, in_i.value};
  end

  assign kind     = kind_e'(in_i.kind);
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign out_free = !out_vld_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (kind == KIND_FIND)) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (probe_vld[DEPTH]) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and command logic.
  always_comb begin
    in_i.ready   = 1'b0;
    cmd          = '0;
    probe_start  = 1'b0;
    count_d      = count_q;
    out_load     = 1'b0;
    out_status_d = STATUS_OK;
    out_pos_d    = '0;
    out_count_d  = count_q;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = out_free;
        if (accept) begin
          out_load = (kind != KIND_FIND);
          unique case (kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
              if (is_full) begin
                out_status_d = STATUS_FULL;
              end else begin
                cmd.write_back = (kind == KIND_PUSH_BACK);
                cmd.shift_up   = (kind == KIND_PUSH_FRONT);
                count_d        = count_q + CntW'(1);
              end
            end
            KIND_POP_BACK, KIND_POP_FRONT: begin
              if (is_empty) begin
                out_status_d = STATUS_EMPTY;
              end else begin
                cmd.shift_down = (kind == KIND_POP_FRONT);
                count_d        = count_q - CntW'(1);
              end
            end
            KIND_FIND: begin
              probe_start = 1'b1;
            end
            default: begin
              out_status_d = STATUS_OK;
            end
          endcase
          out_count_d = count_d;
        end
      end
      ST_SEARCH: begin
        if (probe_vld[DEPTH]) begin
          out_load     = 1'b1;
          out_status_d = probe_found[DEPTH] ? STATUS_OK : STATUS_MISS;
          out_pos_d    = probe_found[DEPTH] ? probe_pos[DEPTH] : '0;
        end
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_pos_q    <= out_pos_d;
      out_count_q  <= out_count_d;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.status   = out_status_q;
  assign out_o.position = out_pos_q;
  assign out_o.count    = out_count_q;

  // Probe launch into the head of the chain.
  assign probe_vld[0]   = probe_start;
  assign probe_word[0]  = ins_word;
  assign probe_left[0]  = count_q;
  assign probe_found[0] = 1'b0;
  assign probe_pos[0]   = '0;

  // Chain of list cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] lower_word;
    logic [WORD_BITS-1:0] upper_word;

    if (i == 0) begin : g_head
      assign lower_word = ins_word;
    end else begin : g_body
      assign lower_word = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign upper_word = '0;
    end else begin : g_inner
      assign upper_word = entry_w[i+1];
    end

    sle_cell #(
      .WORD_BITS (WORD_BITS),
      .POS_W     (PosW),
      .CNT_W     (CntW),
      .INDEX     (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .count_i       (count_q),
      .ins_word_i    (ins_word),
      .lower_word_i  (lower_word),
      .upper_word_i  (upper_word),
      .entry_o       (entry_w[i]),
      .probe_vld_i   (probe_vld[i]),
      .probe_word_i  (probe_word[i]),
      .probe_left_i  (probe_left[i]),
      .probe_found_i (probe_found[i]),
      .probe_pos_i   (probe_pos[i]),
      .probe_vld_o   (probe_vld[i+1]),
      .probe_word_o  (probe_word[i+1]),
      .probe_left_o  (probe_left[i+1]),
      .probe_found_o (probe_found[i+1]),
      .probe_pos_o   (probe_pos[i+1])
    );
  end

endmodule
